/* design/amsvt_pkg.sv */
// Shared types, opcodes and constants of the affine vertex transform block.
// Used by every module of the block; depends on nothing else.
package amsvt_pkg;

  // Opcodes as they arrive on the input stream
  typedef enum logic [3:0] {
    OP_VERTEX    = 4'd0,
    OP_PUSH      = 4'd1,
    OP_POP       = 4'd2,
    OP_TRANSLATE = 4'd3,
    OP_ROTATE    = 4'd4,
    OP_SCALE     = 4'd5,
    OP_BLEND     = 4'd6,
    OP_TEXTURE   = 4'd7,
    OP_ALPHA     = 4'd8,
    OP_COLOUR    = 4'd9,
    OP_RESET     = 4'd10
  } op_t;

  // Sequencer states of the back end
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_MUL,
    ST_ADD,
    ST_POP,
    ST_OUT
  } back_state_t;

  // One decoded item as held in the queue between front and back
  typedef struct packed {
    op_t                op;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
    logic signed [31:0] factor_x;
    logic signed [31:0] factor_y;
    logic [15:0]        angle;
    logic [15:0]        texture_id;
    logic               blend_add;
    logic [7:0]         alpha_byte;
    logic [23:0]        rgb_word;
  } item_t;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int IN_DATA_W       = 264;
  localparam int OUT_DATA_W      = 184;

  localparam logic signed [31:0] ONE_Q16      = 32'sh0001_0000;
  localparam logic signed [31:0] MINUS_HALF   = -32'sh0000_8000;
  localparam logic signed [31:0] ROUND_HALF   = 32'sh0000_8000;
  localparam logic [31:0]        WHITE_ARGB   = 32'hFFFF_FFFF;
  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
  localparam logic signed [33:0] CORDIC_ROUND = 34'sd8192;
  localparam int                 CORDIC_STEPS = 24;

  // Arctangent of 2^-i in units of 2^32 per turn
  function automatic logic signed [33:0] atan_turns(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0:  r = 34'sd536870912;
      5'd1:  r = 34'sd316933406;
      5'd2:  r = 34'sd167458907;
      5'd3:  r = 34'sd85004756;
      5'd4:  r = 34'sd42667331;
      5'd5:  r = 34'sd21354465;
      5'd6:  r = 34'sd10679838;
      5'd7:  r = 34'sd5340245;
      5'd8:  r = 34'sd2670163;
      5'd9:  r = 34'sd1335087;
      5'd10: r = 34'sd667544;
      5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;
      5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;
      5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;
      5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;
      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;
      5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;
      5'd23: r = 34'sd81;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

endpackage

/* design/amsvt_front.sv */
// Front end: takes words from the input stream, decodes the opcode and
// queues valid items in a two-entry queue. Depends on amsvt_pkg.
module amsvt_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [amsvt_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic [3:0]                      s_tuser,
  output logic                            q_valid,
  input  logic                            q_pop,
  output amsvt_pkg::item_t                q_item
);

  amsvt_pkg::item_t q_mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       q_count;
  amsvt_pkg::item_t item;
  logic             known;
  logic             push;
  logic             pop;

  // Unpack the word and classify the opcode
  always_comb begin
    item.op         = amsvt_pkg::op_t'(s_tuser);
    item.pos_x      = s_tdata[31:0];
    item.pos_y      = s_tdata[63:32];
    item.tex_u      = s_tdata[95:64];
    item.tex_v      = s_tdata[127:96];
    item.factor_x   = s_tdata[159:128];
    item.factor_y   = s_tdata[191:160];
    item.angle      = s_tdata[207:192];
    item.texture_id = s_tdata[223:208];
    item.blend_add  = s_tdata[224];
    item.alpha_byte = s_tdata[232:225];
    item.rgb_word   = s_tdata[256:233];
    known           = (s_tuser <= amsvt_pkg::OP_RESET);
  end

  assign s_tready = (q_count != 2'd2);
  assign push     = s_tvalid && s_tready && known;
  assign pop      = q_pop && q_valid;
  assign q_valid  = (q_count != 2'd0);
  assign q_item   = q_mem[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= item;
    end
  end

  // Queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= 1'b0;
      rd_ptr  <= 1'b0;
      q_count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      q_count <= q_count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* design/amsvt_cordic.sv */
// Iterative CORDIC giving cosine and sine in Q16.16, one rotation per cycle.
// Depends on amsvt_pkg for the arctangent table and start value.
module amsvt_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [15:0]        angle,
  output logic               done,
  output logic signed [31:0] cos_q,
  output logic signed [31:0] sin_q
);

  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [33:0] z;
  logic [4:0]         step;
  logic               busy;
  logic               fin;
  logic [1:0]         quad;
  logic signed [33:0] xr;
  logic signed [33:0] yr;
  logic signed [31:0] cr;
  logic signed [31:0] sr;

  // Round the final vector to Q16.16
  always_comb begin
    xr = (x + amsvt_pkg::CORDIC_ROUND) >>> 14;
    yr = (y + amsvt_pkg::CORDIC_ROUND) >>> 14;
    cr = xr[31:0];
    sr = yr[31:0];
  end

  // Control: a run of rotations, then rounding; quarter turns skip both
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (start) begin
        quad <= angle[15:14];
        step <= 5'd0;
        if (angle[13:0] == 14'd0) begin
          done <= 1'b1;
          case (angle[15:14])
            2'd0: begin cos_q <= amsvt_pkg::ONE_Q16;  sin_q <= 32'sd0; end
            2'd1: begin cos_q <= 32'sd0;  sin_q <= amsvt_pkg::ONE_Q16; end
            2'd2: begin cos_q <= -amsvt_pkg::ONE_Q16; sin_q <= 32'sd0; end
            default: begin cos_q <= 32'sd0; sin_q <= -amsvt_pkg::ONE_Q16; end
          endcase
        end else begin
          busy <= 1'b1;
          x    <= amsvt_pkg::CORDIC_START;
          y    <= 34'sd0;
          z    <= {4'd0, angle[13:0], 16'd0};
        end
      end else if (busy) begin
        if (z >= 0) begin
          x <= x - (y >>> step);
          y <= y + (x >>> step);
          z <= z - amsvt_pkg::atan_turns(step);
        end else begin
          x <= x + (y >>> step);
          y <= y - (x >>> step);
          z <= z + amsvt_pkg::atan_turns(step);
        end
        step <= step + 5'd1;
        if (step == 5'(amsvt_pkg::CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        done <= 1'b1;
        case (quad)
          2'd0: begin cos_q <= cr;  sin_q <= sr;  end
          2'd1: begin cos_q <= -sr; sin_q <= cr;  end
          2'd2: begin cos_q <= -cr; sin_q <= -sr; end
          default: begin cos_q <= sr; sin_q <= -cr; end
        endcase
      end
    end
  end

endmodule

/* design/amsvt_back.sv */
// Back end: holds the current transform and attributes, the save stack and
// the output register; runs a shared multiplier pair. Needs amsvt_pkg, amsvt_cordic.
module amsvt_back #(
  parameter int STACK_DEPTH = amsvt_pkg::STACK_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  output logic                             q_pop,
  input  amsvt_pkg::item_t                 q_item,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [amsvt_pkg::OUT_DATA_W-1:0] m_tdata
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int EW = 32 * 7 + 16 + 1;

  amsvt_pkg::back_state_t state, state_next;
  amsvt_pkg::item_t       cur;
  logic signed [31:0] lin_xx, lin_xy, lin_yx, lin_yy, shift_x, shift_y;
  logic [15:0]        cur_texture;
  logic               cur_blend;
  logic [31:0]        cur_color;
  logic [CW-1:0]      stack_count;
  logic [EW-1:0]      stack_mem [STACK_DEPTH];
  logic [EW-1:0]      rd_data;
  logic [AW-1:0]      rd_addr;
  logic [1:0]         idx;
  logic [1:0]         last_idx;
  logic signed [31:0] res [4];
  logic signed [63:0] prod_p, prod_q;
  logic signed [31:0] add_r;
  logic signed [31:0] op_a, op_b, op_c, op_d, op_add;
  logic signed [65:0] sum;
  logic signed [66:0] total;
  logic signed [31:0] mac_val;
  logic               cordic_start;
  logic               cordic_done;
  logic signed [31:0] cos_q, sin_q;
  logic signed [31:0] cs, sn;
  logic               out_load;
  logic               stack_full;

  amsvt_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .angle (q_item.angle),
    .done  (cordic_done),
    .cos_q (cos_q),
    .sin_q (sin_q)
  );

  assign stack_full = (stack_count >= CW'(STACK_DEPTH));
  assign last_idx   = ((cur.op == amsvt_pkg::OP_ROTATE) ||
                       (cur.op == amsvt_pkg::OP_SCALE)) ? 2'd3 : 2'd1;

  // Operand selection for the multiplier pair
  always_comb begin
    op_a = 32'sd0; op_b = 32'sd0; op_c = 32'sd0; op_d = 32'sd0; op_add = 32'sd0;
    case (cur.op)
      amsvt_pkg::OP_ROTATE: begin
        op_a = idx[1] ? -sn : cs;
        op_c = idx[1] ? cs : sn;
        op_b = idx[0] ? lin_xy : lin_xx;
        op_d = idx[0] ? lin_yy : lin_yx;
      end
      amsvt_pkg::OP_SCALE: begin
        op_a = idx[1] ? cur.factor_y : cur.factor_x;
        case (idx)
          2'd0: op_b = lin_xx;
          2'd1: op_b = lin_xy;
          2'd2: op_b = lin_yx;
          default: op_b = lin_yy;
        endcase
      end
      default: begin
        op_a   = cur.pos_x;
        op_c   = cur.pos_y;
        op_b   = idx[0] ? lin_xy : lin_xx;
        op_d   = idx[0] ? lin_yy : lin_yx;
        op_add = idx[0] ? shift_y : shift_x;
      end
    endcase
  end

  // Round half up, add the offset, saturate to 32 bits
  always_comb begin
    sum   = 66'(prod_p) + 66'(prod_q) + 66'(amsvt_pkg::ROUND_HALF);
    total = 67'(sum >>> 16) + 67'(add_r);
    if (total > 67'sd2147483647) begin
      mac_val = 32'sh7FFF_FFFF;
    end else if (total < -67'sd2147483648) begin
      mac_val = -32'sh8000_0000;
    end else begin
      mac_val = total[31:0];
    end
  end

  assign out_load = (state == amsvt_pkg::ST_OUT) && (!m_tvalid || m_tready);

  // Next state and handshake outputs
  always_comb begin
    state_next   = state;
    q_pop        = 1'b0;
    cordic_start = 1'b0;
    case (state)
      amsvt_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_item.op)
            amsvt_pkg::OP_VERTEX, amsvt_pkg::OP_TRANSLATE,
            amsvt_pkg::OP_SCALE: state_next = amsvt_pkg::ST_MUL;
            amsvt_pkg::OP_ROTATE: begin
              cordic_start = 1'b1;
              state_next   = amsvt_pkg::ST_CORDIC;
            end
            amsvt_pkg::OP_POP: begin
              if (stack_count != '0) state_next = amsvt_pkg::ST_POP;
            end
            default: state_next = amsvt_pkg::ST_IDLE;
          endcase
        end
      end
      amsvt_pkg::ST_CORDIC: if (cordic_done) state_next = amsvt_pkg::ST_MUL;
      amsvt_pkg::ST_MUL:    state_next = amsvt_pkg::ST_ADD;
      amsvt_pkg::ST_ADD: begin
        if (idx != last_idx) state_next = amsvt_pkg::ST_MUL;
        else if (cur.op == amsvt_pkg::OP_VERTEX) state_next = amsvt_pkg::ST_OUT;
        else state_next = amsvt_pkg::ST_IDLE;
      end
      amsvt_pkg::ST_POP: state_next = amsvt_pkg::ST_IDLE;
      amsvt_pkg::ST_OUT: if (out_load) state_next = amsvt_pkg::ST_IDLE;
      default: state_next = amsvt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= amsvt_pkg::ST_IDLE;
    else state <= state_next;
  end

  // Save stack memory, registered read
  always_ff @(posedge clk) begin
    if (state == amsvt_pkg::ST_IDLE && q_valid && q_item.op == amsvt_pkg::OP_PUSH &&
        !stack_full) begin
      stack_mem[stack_count[AW-1:0]] <= {lin_xx, lin_xy, lin_yx, lin_yy, shift_x, shift_y,
                                         cur_color, cur_texture, cur_blend};
    end
    rd_data <= stack_mem[rd_addr];
  end

  assign rd_addr = AW'(stack_count - CW'(1));

  // Datapath: multiplier pair, result registers, item latch
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
      idx <= 2'd0;
    end
    if (cordic_done) begin
      cs <= cos_q;
      sn <= sin_q;
    end
    if (state == amsvt_pkg::ST_MUL) begin
      prod_p <= op_a * op_b;
      prod_q <= op_c * op_d;
      add_r  <= op_add;
    end
    if (state == amsvt_pkg::ST_ADD) begin
      res[idx] <= mac_val;
      idx      <= idx + 2'd1;
    end
  end

  // Architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      lin_xx <= amsvt_pkg::ONE_Q16; lin_xy <= 32'sd0;
      lin_yx <= 32'sd0; lin_yy <= amsvt_pkg::ONE_Q16;
      shift_x <= amsvt_pkg::MINUS_HALF; shift_y <= amsvt_pkg::MINUS_HALF;
      cur_texture <= 16'd0; cur_blend <= 1'b0; cur_color <= amsvt_pkg::WHITE_ARGB;
      stack_count <= '0;
    end else begin
      if (state == amsvt_pkg::ST_IDLE && q_valid) begin
        case (q_item.op)
          amsvt_pkg::OP_PUSH:    if (!stack_full) stack_count <= stack_count + CW'(1);
          amsvt_pkg::OP_POP:     if (stack_count != '0) stack_count <= stack_count - CW'(1);
          amsvt_pkg::OP_BLEND:   cur_blend <= q_item.blend_add;
          amsvt_pkg::OP_TEXTURE: cur_texture <= q_item.texture_id;
          amsvt_pkg::OP_ALPHA:   cur_color[31:24] <= q_item.alpha_byte;
          amsvt_pkg::OP_COLOUR:  cur_color[23:0] <= q_item.rgb_word;
          amsvt_pkg::OP_RESET: begin
            lin_xx <= amsvt_pkg::ONE_Q16; lin_xy <= 32'sd0;
            lin_yx <= 32'sd0; lin_yy <= amsvt_pkg::ONE_Q16;
            shift_x <= amsvt_pkg::MINUS_HALF; shift_y <= amsvt_pkg::MINUS_HALF;
            cur_texture <= 16'd0; cur_blend <= 1'b0;
            cur_color <= amsvt_pkg::WHITE_ARGB;
            stack_count <= '0;
          end
          default: ;
        endcase
      end
      if (state == amsvt_pkg::ST_POP) begin
        {lin_xx, lin_xy, lin_yx, lin_yy, shift_x, shift_y,
         cur_color, cur_texture, cur_blend} <= rd_data;
      end
      // Commit of the multiply results on the last accumulation
      if (state == amsvt_pkg::ST_ADD && idx == last_idx) begin
        case (cur.op)
          amsvt_pkg::OP_TRANSLATE: begin
            shift_x <= res[0];
            shift_y <= mac_val;
          end
          amsvt_pkg::OP_ROTATE, amsvt_pkg::OP_SCALE: begin
            lin_xx <= res[0];
            lin_xy <= res[1];
            lin_yx <= res[2];
            lin_yy <= mac_val;
          end
          default: ;
        endcase
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {7'd0, cur_blend, cur_texture, cur_color, cur.tex_v, cur.tex_u,
                  res[1], res[0]};
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stack_count <= CW'(STACK_DEPTH))
    else $error("stack fill beyond its depth");

  a_out_vertex: assert property (@(posedge clk) disable iff (rst)
    state == amsvt_pkg::ST_OUT |-> cur.op == amsvt_pkg::OP_VERTEX)
    else $error("result pending for an item that is not a vertex");

  a_cordic_rotate: assert property (@(posedge clk) disable iff (rst)
    state == amsvt_pkg::ST_CORDIC |-> cur.op == amsvt_pkg::OP_ROTATE)
    else $error("sine wait for an item that is not a rotation");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == amsvt_pkg::ST_POP |-> $past(stack_count) != '0)
    else $error("restore from an empty stack");
`endif

endmodule

/* design/affine_matrix_stack_vertex_transform.sv */
// 2D affine vertex transform with a save stack of STACK_DEPTH entries. Each
// command word passes the input queue, then in the back end: attribute,
// push and reset commands are applied in idle, pop restores via the
// registered stack read, translate and vertex compute two terms, vertex
// then waits until the output register can take its word, scale computes
// four terms, and rotate first waits for the CORDIC (24 rotations, one per
// cycle, then a rounding step, both skipped for a multiple of a quarter
// turn), then computes four terms; each term takes a multiply state and an
// accumulate state on one shared pair of 32x32 multipliers. Only vertex
// commands produce an output word. Unused opcodes are dropped. Top level:
// wires the front queue to the back end. Needs amsvt_pkg, amsvt_front and amsvt_back.
module affine_matrix_stack_vertex_transform #(
  parameter int STACK_DEPTH = amsvt_pkg::STACK_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // pos_x, pos_y, tex_u, tex_v, factor_x, factor_y, angle, texture_id,
  // blend_add, alpha_byte, rgb_word, zero fill
  input  logic [amsvt_pkg::IN_DATA_W-1:0]  s_tdata,
  // opcode
  input  logic [3:0]                       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // out_x, out_y, out_u, out_v, out_color, out_texture, out_blend_add, zero fill
  output logic [amsvt_pkg::OUT_DATA_W-1:0] m_tdata
);

  logic             q_valid;
  logic             q_pop;
  amsvt_pkg::item_t q_item;

  amsvt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  amsvt_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
